@@ hw/rtl/polynomial_rolling_hash_macros.svh @@
// Assertion macros shared by the rolling hash RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef POLYNOMIAL_ROLLING_HASH_MACROS_SVH
`define POLYNOMIAL_ROLLING_HASH_MACROS_SVH

// Property checked on every clock, held off during reset.
`define PRH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/prh_pkg.sv @@
// Package for the polynomial rolling hash: modulus constants, reduction
// helpers, fold tables and the operand struct between pipe and hash stage.
// No dependencies.
package prh_pkg;

    localparam logic [29:0]       HASH_MOD    = 30'd1000000009;
    localparam logic [63:0]       HASH_MOD_W  = 64'd1000000009;
    localparam logic [31:0]       HASH_MOD_X2 = 32'd2000000018;
    localparam logic [63:0]       HASH_BASE_W = 64'd257;
    localparam logic signed [8:0] CHAR_OFFSET = 9'sd96;

    // 2^64 mod M: what a 64-bit wrap of a negative sum adds back
    localparam logic [63:0] WRAP_RES_W =
        ((64'hFFFF_FFFF_FFFF_FFFF % HASH_MOD_W) + 64'd1) % HASH_MOD_W;
    localparam logic [29:0] WRAP_RES = WRAP_RES_W[29:0];

    typedef logic [29:0] fold_tbl_t [256];

    // Entry i holds (i * scale) mod M, built at elaboration
    function automatic fold_tbl_t fold_tbl_init(input logic [63:0] scale);
        fold_tbl_t   tbl;
        logic [63:0] prod;
        for (int i = 0; i < 256; i++)
        begin
            prod   = (64'(i) * scale) % HASH_MOD_W;
            tbl[i] = prod[29:0];
        end
        return tbl;
    endfunction

    // Power step: top byte of the power (bits 29:22) times 257 * 2^22
    localparam fold_tbl_t POW_FOLD  = fold_tbl_init(HASH_BASE_W << 22);
    // Product fold: bits 37:30 of the product times 2^30
    localparam fold_tbl_t PROD_FOLD = fold_tbl_init(64'd1 << 30);

    // Reduce a value below 2M
    function automatic logic [29:0] mod_lt2(input logic [30:0] y);
        logic [30:0] d;
        d = y - 31'(HASH_MOD);
        return (y >= 31'(HASH_MOD)) ? d[29:0] : y[29:0];
    endfunction

    // Reduce a value below 3M
    function automatic logic [29:0] mod_lt3(input logic [31:0] y);
        logic [31:0] d1;
        logic [31:0] d2;
        d1 = y - 32'(HASH_MOD);
        d2 = y - HASH_MOD_X2;
        if (y >= HASH_MOD_X2)
            return d2[29:0];
        else if (y >= 32'(HASH_MOD))
            return d1[29:0];
        else
            return y[29:0];
    endfunction

    // Operands handed to the hash stage for one byte
    typedef struct packed {
        logic [29:0] b;       // term * power mod M
        logic [29:0] b_wrap;  // (b + 2^64) mod M
        logic        m_big;   // |term| * power >= 2^30
        logic [29:0] m_lo;    // low bits of |term| * power
        logic        neg;     // term is negative
        logic        last;    // final byte of the string
    } hash_op_t;

endpackage

@@ hw/rtl/prh_power.sv @@
// Running power of 257 modulo M, one step per accepted byte.
// Depends on prh_pkg and the assertion macro header.
`include "polynomial_rolling_hash_macros.svh"

module prh_power (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,     // byte accepted this cycle
    input  logic        restart,  // that byte ends the string
    output logic [29:0] power     // power for the next byte
);
    import prh_pkg::*;

    logic [29:0] power_reg;
    logic [29:0] power_next;
    logic [31:0] fold_sum;

    // 257 * p = table(p[29:22]) + 257 * p[21:0], below 3M
    assign fold_sum = 32'(POW_FOLD[power_reg[29:22]])
                    + (32'(power_reg[21:0]) << 8)
                    + 32'(power_reg[21:0]);

    always_comb
    begin
        if (restart)
            power_next = 30'd1;
        else
            power_next = mod_lt3(fold_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            power_reg <= 30'd1;
        else if (step)
            power_reg <= power_next;
    end

    assign power = power_reg;

    `PRH_ASSERT(a_power_range, power_reg < HASH_MOD, "power left the residue range")
    `PRH_ASSERT_NEXT(a_power_restart, step && restart, power_reg == 30'd1,
        "power not restarted after final byte")

endmodule

@@ hw/rtl/prh_term_pipe.sv @@
// Term pipeline: input register, term * power multiply, fold modulo M,
// negation and wrap offset. Depends on prh_pkg.
module prh_term_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic [29:0]       power,
    output logic              op_valid,
    input  logic              op_ready,
    output prh_pkg::hash_op_t op
);
    import prh_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    // stage 1: input register
    logic signed [8:0] term;
    logic [7:0]        mag_next;
    logic              neg1_reg;
    logic [7:0]        mag1_reg;
    logic [29:0]       pow1_reg;
    logic              last1_reg;

    // stage 2: product
    logic [37:0]       prod_next;
    logic [37:0]       prod2_reg;
    logic              neg2_reg;
    logic              last2_reg;

    // stage 3: residue of the magnitude
    logic [29:0]       rem_next;
    logic [29:0]       rem3_reg;
    logic              m_big3_reg;
    logic [29:0]       m_lo3_reg;
    logic              neg3_reg;
    logic              last3_reg;

    // stage 4: signed residue and wrapped residue
    logic [29:0]       b_next;
    logic [29:0]       b_wrap_next;
    hash_op_t          op_reg;

    assign r4 = !v4_reg || op_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    // signed byte minus 96 lies in -224..31
    assign term     = $signed({in_byte[7], in_byte}) - CHAR_OFFSET;
    assign mag_next = term[8] ? 8'(-term) : term[7:0];

    assign prod_next = 38'(mag1_reg) * 38'(pow1_reg);

    assign rem_next = mod_lt3(32'(PROD_FOLD[prod2_reg[37:30]]) + 32'(prod2_reg[29:0]));

    always_comb
    begin
        if (neg3_reg && (rem3_reg != '0))
            b_next = HASH_MOD - rem3_reg;
        else
            b_next = rem3_reg;
        b_wrap_next = mod_lt2(31'(b_next) + 31'(WRAP_RES));
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            neg1_reg  <= term[8];
            mag1_reg  <= mag_next;
            pow1_reg  <= power;
            last1_reg <= in_last;
        end
        if (r2)
        begin
            prod2_reg <= prod_next;
            neg2_reg  <= neg1_reg;
            last2_reg <= last1_reg;
        end
        if (r3)
        begin
            rem3_reg   <= rem_next;
            m_big3_reg <= |prod2_reg[37:30];
            m_lo3_reg  <= prod2_reg[29:0];
            neg3_reg   <= neg2_reg;
            last3_reg  <= last2_reg;
        end
        if (r4)
        begin
            op_reg.b      <= b_next;
            op_reg.b_wrap <= b_wrap_next;
            op_reg.m_big  <= m_big3_reg;
            op_reg.m_lo   <= m_lo3_reg;
            op_reg.neg    <= neg3_reg;
            op_reg.last   <= last3_reg;
        end
    end

    assign op_valid = v4_reg;
    assign op       = op_reg;

endmodule

@@ hw/rtl/prh_hash_out.sv @@
// Hash accumulator and result register: one modular add per byte.
// Depends on prh_pkg and the assertion macro header.
`include "polynomial_rolling_hash_macros.svh"

module prh_hash_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_ready,
    input  prh_pkg::hash_op_t op,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [29:0]       out_hash,
    output logic              out_last
);
    import prh_pkg::*;

    logic [29:0] hash_reg;
    logic        out_valid_reg;
    logic [29:0] out_hash_reg;
    logic        out_last_reg;

    logic        load;
    logic        wraps;
    logic [29:0] hash_next;

    assign op_ready = !out_valid_reg || out_ready;
    assign load     = op_valid && op_ready;

    // hash - |term| * power below zero: the 64-bit sum wrapped
    assign wraps = op.neg && (op.m_big || (op.m_lo > hash_reg));

    always_comb
    begin
        if (wraps)
            hash_next = mod_lt2(31'(hash_reg) + 31'(op.b_wrap));
        else
            hash_next = mod_lt2(31'(hash_reg) + 31'(op.b));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                hash_reg <= op.last ? '0 : hash_next;
            if (op_ready)
                out_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_hash_reg <= hash_next;
            out_last_reg <= op.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;
    assign out_last  = out_last_reg;

    `PRH_ASSERT(a_hash_range, hash_reg < HASH_MOD, "hash state left the residue range")
    `PRH_ASSERT(a_out_range, out_valid_reg |-> (out_hash_reg < HASH_MOD),
        "result hash out of range")
    `PRH_ASSERT_NEXT(a_hash_restart, load && op.last, hash_reg == '0,
        "hash not cleared after final byte")

endmodule

@@ hw/rtl/polynomial_rolling_hash.sv @@
// polynomial_rolling_hash: polynomial hash of a byte string modulo 1000000009.
// Depends on prh_pkg, prh_power, prh_term_pipe and prh_hash_out.
//
// Input stream: one string byte per transfer on s_axis; s_axis_tlast marks
// the final byte. Each byte counts as a signed value minus 96, times 257^n.
// Output stream: one result per input byte on m_axis, carrying the running
// hash after that byte; m_axis_tlast copies the input tlast, so the result
// with tlast set is the hash of the whole string.
// Path from input transfer to m_axis_tvalid: input register, product, residue,
// signed residue, result register. Throughput: one byte per cycle while
// m_axis_tready keeps up, set by the hash add/reduce feedback and the power step
// (fold table plus 257x shift-add and reduce). Stalls: m_axis_tready low holds
// the result register; the five-deep pipeline keeps taking bytes until it fills, then s_axis_tready drops.
// Reset (rst_n low, asynchronous): pipeline emptied, hash 0, power 1.
// After a final byte the hash and power return to those values.
module polynomial_rolling_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [29:0] hash_value, [31:30] zero
    output logic        m_axis_tlast    // final_res
);
    import prh_pkg::*;

    logic        in_xfer;
    logic [29:0] power;
    logic        op_valid;
    logic        op_ready;
    hash_op_t    op;
    logic [29:0] out_hash;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // power for the byte being taken; steps on every input transfer
    prh_power u_power (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_xfer),
        .restart (s_axis_tlast),
        .power   (power)
    );

    // term * power reduced to residues, four stages
    prh_term_pipe u_term_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .power    (power),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // hash accumulator and the result register
    prh_hash_out u_hash_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (out_hash),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_hash};

endmodule

@@ tb/polynomial_rolling_hash_checker.sv @@
// Scoreboard for polynomial_rolling_hash: predicts the running hash of every
// accepted byte and checks each result transfer against it.
// Stand-alone; needs only the port-level view of the block.
`timescale 1ns / 1ps

module polynomial_rolling_hash_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          pending,
    output int          bytes_in,
    output int          results_out,
    output int          strings_done
);

    localparam logic [63:0]        MODULUS     = 64'd1000000009;
    localparam logic [63:0]        RADIX       = 64'd257;
    localparam logic signed [63:0] BYTE_OFFSET = 64'sd96;

    typedef struct packed {
        logic [29:0] hash;
        logic        whole;
    } hash_word_t;

    logic [63:0] run_hash;
    logic [63:0] run_power;
    hash_word_t  hash_q[$];

    // Fold one byte into the running hash and queue the word it produces
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic signed [63:0] term;
        logic [63:0]        sum;
        hash_word_t         w;
        term      = 64'($signed(b)) - BYTE_OFFSET;
        sum       = run_hash + (64'(term) * run_power);   // wraps at 2^64
        run_hash  = sum % MODULUS;
        run_power = (run_power * RADIX) % MODULUS;
        w.hash    = run_hash[29:0];
        w.whole   = fin;
        hash_q.push_back(w);
        if (fin)
        begin
            run_hash  = 64'd0;
            run_power = 64'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        $display("[%0t] mismatch on %s: expected %0d, got %0d (result %0d)",
                 $time, what, exp_v, got_v, results_out);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        hash_word_t w;
        if (!rst_n)
        begin
            run_hash     = 64'd0;
            run_power    = 64'd1;
            hash_q.delete();
            mismatches   = 0;
            bytes_in     = 0;
            results_out  = 0;
            strings_done = 0;
        end
        else
        begin
            // result side first: a byte taken at this edge cannot be answered yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (hash_q.size() == 0)
                    report_mismatch("unexpected result", 0, m_axis_tdata);
                else
                begin
                    w = hash_q.pop_front();
                    if (m_axis_tdata[29:0] !== w.hash)
                        report_mismatch("hash", w.hash, m_axis_tdata[29:0]);
                    if (m_axis_tdata[31:30] !== 2'b00)
                        report_mismatch("tdata pad", 0, m_axis_tdata[31:30]);
                    if (m_axis_tlast !== w.whole)
                        report_mismatch("tlast", w.whole, m_axis_tlast);
                end
                results_out++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_byte(s_axis_tdata, s_axis_tlast);
                bytes_in++;
                if (s_axis_tlast)
                    strings_done++;
            end
        end
        pending = hash_q.size();
    end

endmodule

@@ tb/polynomial_rolling_hash_tb.sv @@
// Testbench top for polynomial_rolling_hash: clock, reset, byte-string
// stimulus, result back-pressure and verdict.
// Needs polynomial_rolling_hash and polynomial_rolling_hash_checker.
`timescale 1ns / 1ps

module polynomial_rolling_hash_tb;

    localparam int RANDOM_BYTES = 1500;
    localparam int CALM_FROM    = 1200;    // no idling beyond this many bytes
    localparam int LONG_HOLD    = 60;      // receiver hold-off, in cycles
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;      // margin after the last result is checked

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic tx_idles;
    logic rx_idles;
    logic hold_req;
    logic hold_served;

    int mismatches;
    int pending;
    int bytes_in;
    int results_out;
    int strings_done;
    int cycles;

    polynomial_rolling_hash u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    polynomial_rolling_hash_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending),
        .bytes_in      (bytes_in),
        .results_out   (results_out),
        .strings_done  (strings_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, pending);
                $display("FAIL polynomial_rolling_hash");
                $finish;
            end
        end
    end

    // Result side: short random stalls, plus one long hold-off on request so
    // the pipe fills and s_axis_tready drops.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_served   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_served = 1'b1;
            end
            else if (rx_idles && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // One byte transfer, with an optional idle burst in front of it.
    // Entered just after a rising edge; returns at the edge that took the byte.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (tx_idles && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        // tready settles well before the falling edge
        do
            @(negedge clk);
        while (s_axis_tready !== 1'b1);
        @(posedge clk);
    endtask

    task automatic send_string(input logic [7:0] str[$]);
        foreach (str[i])
            send_byte(str[i], i == str.size() - 1);
    endtask

    // Half fully random bytes, some lowercase text, some at the signed extremes
    function automatic logic [7:0] pick_byte();
        logic [7:0] extremes[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        int         roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return 8'($urandom_range(0, 255));
        else if (roll < 8)
            return 8'($urandom_range(8'h61, 8'h7A));
        else
            return extremes[$urandom_range(0, 3)];
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 3)
            return 1;
        else if (roll < 18)
            return $urandom_range(2, 24);
        else
            return $urandom_range(25, 160);   // power well into wrap-around
    endfunction

    initial
    begin
        logic [7:0] str[$];
        int         len;
        int         sent;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        tx_idles      = 1'b0;
        rx_idles      = 1'b0;
        hold_req      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: single bytes with term 1 and term 0, every
        // signed extreme and both sides of the offset, a run of all-ones
        // bytes (negative terms on a growing power) and a short pair.
        str = '{8'h61};
        send_string(str);
        str = '{8'h60};
        send_string(str);
        str = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h5F, 8'h61, 8'h60, 8'h20};
        send_string(str);
        str = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_string(str);
        str = '{8'h80, 8'h7F};
        send_string(str);

        tx_idles <= 1'b1;
        rx_idles <= 1'b1;

        // Receiver holds off while a long string keeps coming
        hold_req <= 1'b1;
        str.delete();
        repeat (30) str.push_back(pick_byte());
        send_string(str);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (sent >= CALM_FROM)
            begin
                tx_idles <= 1'b0;
                rx_idles <= 1'b0;
            end
            len = pick_length();
            str.delete();
            repeat (len) str.push_back(pick_byte());
            send_string(str);
            sent += len;
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d strings, %0d results checked",
                 bytes_in, strings_done, results_out);
        $display("random stalls on both sides, one %0d-cycle output hold-off",
                 LONG_HOLD);
        if (mismatches == 0)
            $display("PASS polynomial_rolling_hash");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAIL polynomial_rolling_hash");
        end
        $finish;
    end

endmodule
